// File: rtl/core/rtp_h264_depacketizer_defines.svh
// Assertion macros for the RTP to H.264 depacketizer.
// Used by the top level; depends on signals named clk and arst_n in scope.
`ifndef RTP_H264_DEPACKETIZER_DEFINES_SVH
`define RTP_H264_DEPACKETIZER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RTPD_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RTPD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/core/rtpd_pkg.sv
// Shared types and constants of the RTP to H.264 depacketizer.
// No dependencies; imported by every module of the block.
package rtpd_pkg;

	localparam int DEF_HEADER_BYTES = 12;
	localparam int DEF_QUEUE_DEPTH = 4;

	localparam logic [4:0] NAL_TYPE_FU_A = 5'h1c;
	localparam logic [2:0] FU_FLAGS_START = 3'b100;
	localparam logic [7:0] START_CODE_ZERO = 8'h00;
	localparam logic [7:0] START_CODE_ONE = 8'h01;

	typedef struct packed {
		logic prefix;
		logic [7:0] data;
		logic has;
		logic last;
		logic fend;
		logic err;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_status_t;

endpackage

// File: rtl/core/rtpd_front.sv
// Front end: accepts packet bytes, tracks the header position and classifies the payload.
// Depends on rtpd_pkg; produces one command per transaction that yields output.
module rtpd_front import rtpd_pkg::*; #(
	parameter int HEADER_BYTES = DEF_HEADER_BYTES
) (
	input logic clk,
	input logic arst_n,
	input logic accept,
	input logic [7:0] in_byte,
	input logic in_last,
	output logic cmd_valid,
	output cmd_t cmd
);

	localparam int PW = $clog2(HEADER_BYTES + 3);
	localparam logic [PW-1:0] POS_HDR = PW'(HEADER_BYTES);
	localparam logic [PW-1:0] POS_FU = PW'(HEADER_BYTES + 1);
	localparam logic [PW-1:0] POS_SAT = PW'(HEADER_BYTES + 2);
	localparam logic [PW-1:0] POS_MARK = PW'(1);

	logic [PW-1:0] pos_q;
	logic marker_q;
	logic [7:0] first_q;
	logic frag_q;

	always_comb begin
		cmd_valid = 1'b0;
		cmd = '0;
		if (pos_q < POS_HDR) begin
			if (in_last) begin
				cmd_valid = 1'b1;
				cmd.last = 1'b1;
				cmd.err = 1'b1;
			end
		end else if (pos_q == POS_HDR) begin
			if (in_byte[4:0] != NAL_TYPE_FU_A) begin
				cmd_valid = 1'b1;
				cmd.prefix = 1'b1;
				cmd.data = in_byte;
				cmd.has = 1'b1;
				cmd.last = in_last;
				cmd.fend = in_last & marker_q;
			end else if (in_last) begin
				cmd_valid = 1'b1;
				cmd.last = 1'b1;
				cmd.err = 1'b1;
			end
		end else if (pos_q == POS_FU && frag_q) begin
			if (in_byte[7:5] == FU_FLAGS_START) begin
				cmd_valid = 1'b1;
				cmd.prefix = 1'b1;
				cmd.data = {first_q[7:5], in_byte[4:0]};
				cmd.has = 1'b1;
				cmd.last = in_last;
				cmd.fend = in_last & marker_q;
			end else if (in_last) begin
				cmd_valid = 1'b1;
				cmd.last = 1'b1;
				cmd.fend = marker_q;
			end
		end else begin
			cmd_valid = 1'b1;
			cmd.data = in_byte;
			cmd.has = 1'b1;
			cmd.last = in_last;
			cmd.fend = in_last & marker_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			marker_q <= 1'b0;
			first_q <= '0;
			frag_q <= 1'b0;
		end else if (accept) begin
			if (pos_q == POS_MARK) begin
				marker_q <= in_byte[7];
			end
			if (pos_q == POS_HDR) begin
				first_q <= in_byte;
				frag_q <= (in_byte[4:0] == NAL_TYPE_FU_A);
			end
			if (in_last) begin
				pos_q <= '0;
				marker_q <= 1'b0;
			end else if (pos_q < POS_SAT) begin
				pos_q <= pos_q + PW'(1);
			end
		end
	end

endmodule

// File: rtl/core/rtpd_queue.sv
// Short command queue that decouples the front end from the output sequencer.
// Depends on rtpd_pkg for the command type.
module rtpd_queue import rtpd_pkg::*; #(
	parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
	input logic clk,
	input logic arst_n,
	input logic push,
	input cmd_t push_cmd,
	input logic pop,
	output cmd_t pop_cmd,
	output queue_status_t status
);

	localparam int AW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam logic [AW-1:0] PTR_LAST = AW'(QUEUE_DEPTH - 1);

	cmd_t slot_q [QUEUE_DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic do_push;
	logic do_pop;

	assign status.full = (count_q == CW'(QUEUE_DEPTH));
	assign status.empty = (count_q == '0);
	assign do_push = push & ~status.full;
	assign do_pop = pop & ~status.empty;
	assign pop_cmd = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + AW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

// File: rtl/core/rtpd_back.sv
// Output sequencer: expands queued commands into output transactions, start codes first.
// Depends on rtpd_pkg; drives the registered output channel.
module rtpd_back import rtpd_pkg::*; (
	input logic clk,
	input logic arst_n,
	input queue_status_t qstat,
	input cmd_t qcmd,
	output logic pop,
	input logic out_stall,
	output logic out_valid,
	output logic [7:0] out_byte,
	output logic has_byte,
	output logic out_last,
	output logic frame_end,
	output logic short_error
);

	logic adv;
	logic busy_q;
	logic [1:0] cnt_q;
	cmd_t hold_q;

	assign adv = ~out_valid | ~out_stall;
	assign pop = adv & ~busy_q & ~qstat.empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
			out_valid <= 1'b0;
		end else if (adv) begin
			if (busy_q) begin
				out_valid <= 1'b1;
				if (cnt_q != '0) begin
					cnt_q <= cnt_q + 2'd1;
				end else begin
					busy_q <= 1'b0;
				end
			end else if (!qstat.empty) begin
				out_valid <= 1'b1;
				if (qcmd.prefix) begin
					busy_q <= 1'b1;
					cnt_q <= 2'd1;
				end
			end else begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (busy_q) begin
				if (cnt_q != '0) begin
					out_byte <= (cnt_q == 2'd3) ? START_CODE_ONE : START_CODE_ZERO;
					has_byte <= 1'b1;
					out_last <= 1'b0;
					frame_end <= 1'b0;
					short_error <= 1'b0;
				end else begin
					out_byte <= hold_q.data;
					has_byte <= hold_q.has;
					out_last <= hold_q.last;
					frame_end <= hold_q.fend;
					short_error <= hold_q.err;
				end
			end else if (!qstat.empty) begin
				hold_q <= qcmd;
				if (qcmd.prefix) begin
					out_byte <= START_CODE_ZERO;
					has_byte <= 1'b1;
					out_last <= 1'b0;
					frame_end <= 1'b0;
					short_error <= 1'b0;
				end else begin
					out_byte <= qcmd.data;
					has_byte <= qcmd.has;
					out_last <= qcmd.last;
					frame_end <= qcmd.fend;
					short_error <= qcmd.err;
				end
			end
		end
	end

endmodule

// File: rtl/core/rtp_h264_depacketizer.sv
// RTP to H.264 Annex B depacketizer, top level.
// Depends on rtpd_pkg, rtpd_front, rtpd_queue, rtpd_back and the defines header.
//
// Input channel: one RTP packet byte per transaction (in_byte, in_last marks the
// final byte), handshake in_valid / in_stall. Output channel: one Annex B byte
// per transaction (out_byte, has_byte, out_last, frame_end, short_error),
// handshake out_valid / out_stall.
// The header bytes are dropped; only the marker bit of header byte 1 is kept and
// reported as frame_end on the final transaction of the packet. A payload that
// opens a NAL unit is preceded by the start code 00 00 00 01.
// An accepted input byte is registered in the command queue, then in the output
// register. Throughput is one byte per cycle while out_stall is low and the queue
// is not full; a byte that opens a NAL unit follows its start code bytes, and the
// queue (four entries by default) buffers input meanwhile. in_stall is high exactly
// while the queue is full. When out_stall is high the output register holds its
// transaction and input continues until the queue fills. Asynchronous reset clears
// all control state and out_valid; queue slots and output data are not reset.
`include "rtp_h264_depacketizer_defines.svh"
module rtp_h264_depacketizer import rtpd_pkg::*; #(
	parameter int HEADER_BYTES = DEF_HEADER_BYTES,
	parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic [7:0] in_byte,
	input logic in_last,
	output logic out_valid,
	input logic out_stall,
	output logic [7:0] out_byte,
	output logic has_byte,
	output logic out_last,
	output logic frame_end,
	output logic short_error
);

	logic accept;
	logic cmd_valid;
	cmd_t cmd;
	cmd_t qcmd;
	logic pop;
	queue_status_t qstat;

	assign in_stall = qstat.full;
	assign accept = in_valid & ~in_stall;

	rtpd_front #(
		.HEADER_BYTES(HEADER_BYTES)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.accept(accept),
		.in_byte(in_byte),
		.in_last(in_last),
		.cmd_valid(cmd_valid),
		.cmd(cmd)
	);

	rtpd_queue #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(accept & cmd_valid),
		.push_cmd(cmd),
		.pop(pop),
		.pop_cmd(qcmd),
		.status(qstat)
	);

	rtpd_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.qstat(qstat),
		.qcmd(qcmd),
		.pop(pop),
		.out_stall(out_stall),
		.out_valid(out_valid),
		.out_byte(out_byte),
		.has_byte(has_byte),
		.out_last(out_last),
		.frame_end(frame_end),
		.short_error(short_error)
	);

	`RTPD_ASSERT_SAME(a_err_shape, out_valid && short_error, out_last && !has_byte && !frame_end, "error transaction is malformed")
	`RTPD_ASSERT_SAME(a_empty_last, out_valid && !has_byte, out_last, "empty transaction is not the final one")
	`RTPD_ASSERT_NEXT(a_drain, !qstat.empty && !out_valid, out_valid, "queued work was not picked up")

endmodule
